>>> design/deauth_burst_detector_assert.svh
// assertion macros for the deauth burst detector
// included by the top level; bodies drop out when SYNTH is defined
`ifndef DEAUTH_BURST_DETECTOR_ASSERT_SVH
`define DEAUTH_BURST_DETECTOR_ASSERT_SVH

`ifndef SYNTH
`define DBD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dbd assertion failed");
`define DBD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dbd assertion failed");
`else
`define DBD_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define DBD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> design/dbd_pkg.sv
// types and constants of the deauth burst detector
// no dependencies
`timescale 1ns / 1ps

package dbd_pkg;

  localparam int unsigned TimeW  = 48;
  localparam int unsigned AddrW  = 48;
  localparam int unsigned CountW = 32;
  localparam int unsigned HitsW  = 16;
  localparam int unsigned WinW   = 24;
  localparam int unsigned HoldW  = 28;
  localparam int unsigned LenW   = 8;
  localparam int unsigned CfgW   = 28;

  localparam logic [3:0] SUBTYPE_DISASSOC = 4'hA;
  localparam logic [3:0] SUBTYPE_DEAUTH   = 4'hC;

  localparam logic [HitsW-1:0] HITS_MAX  = '1;
  localparam logic [TimeW-1:0] TIME_MAX  = '1;

  localparam logic [WinW-1:0]  WINDOW_RESET    = 24'd1000000;
  localparam logic [HitsW-1:0] THRESHOLD_RESET = 16'd5;
  localparam logic [HoldW-1:0] HOLD_RESET      = 28'd5000000;
  localparam logic [LenW-1:0]  MIN_LEN_RESET   = 8'd24;

  typedef enum logic [1:0] {
    CFG_WINDOW    = 2'd0,
    CFG_THRESHOLD = 2'd1,
    CFG_HOLD      = 2'd2,
    CFG_MIN_LEN   = 2'd3
  } cfg_idx_t;

  typedef enum logic {
    KIND_FRAME = 1'b0,
    KIND_QUERY = 1'b1
  } kind_t;

  typedef struct packed {
    logic              kind;
    logic              is_management;
    logic [11:0]       frame_length;
    logic [7:0]        frame_control_low;
    logic [AddrW-1:0]  source_address;
    logic [TimeW-1:0]  now_us;
  } in_item_t;

  typedef struct packed {
    logic              attack_active;
    logic [CountW-1:0] deauth_total;
    logic [CountW-1:0] frame_total;
    logic [AddrW-1:0]  last_attacker;
    logic              attacker_known;
  } out_item_t;

  typedef struct packed {
    logic [WinW-1:0]  window_length_us;
    logic [HitsW-1:0] burst_threshold;
    logic [HoldW-1:0] hold_time_us;
  } burst_cfg_t;

  typedef struct packed {
    logic             fire;
    logic             hit;
    logic [TimeW-1:0] now;
  } burst_req_t;

endpackage

>>> design/dbd_stream_if.sv
// valid/ready stream channel carrying one word of type data_t
// used for both the input and result channels
`timescale 1ns / 1ps

interface dbd_stream_if #(
  parameter type data_t = logic
);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> design/dbd_in_reg.sv
// input register stage: holds one accepted word until the update stage takes it
// depends on dbd_pkg and dbd_stream_if
`timescale 1ns / 1ps

module dbd_in_reg (
  input  logic              clk,
  input  logic              rst_n,
  dbd_stream_if.sink        in_ch,
  input  logic              advance,
  output logic              item_valid,
  output dbd_pkg::in_item_t item
);
  import dbd_pkg::*;

  logic     valid_r;
  logic     valid_nxt;
  in_item_t item_r;
  logic     take;

  // a new word may enter whenever the held one moves on this cycle
  assign in_ch.ready = !valid_r || advance;
  assign take        = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= in_ch.data;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;
endmodule

>>> design/dbd_burst.sv
// burst window, hit counter and attack hold deadline
// depends on dbd_pkg
`timescale 1ns / 1ps

module dbd_burst (
  input  logic                clk,
  input  logic                rst_n,
  input  dbd_pkg::burst_cfg_t cfg,
  input  dbd_pkg::burst_req_t req,
  output logic                attack_active
);
  import dbd_pkg::*;

  logic [TimeW-1:0] window_start_r, window_start_nxt;
  logic [HitsW-1:0] hits_r, hits_nxt;
  logic [TimeW-1:0] deadline_r, deadline_nxt;

  logic [TimeW-1:0] elapsed;
  logic             restart;
  logic [HitsW-1:0] hits_base;
  logic             set_deadline;
  logic [TimeW:0]   sum;
  logic [TimeW-1:0] deadline_cand;
  logic             hit_now;

  assign hit_now = req.fire && req.hit;
  assign elapsed = req.now - window_start_r;

  // clock going backwards never restarts the window
  assign restart = (req.now >= window_start_r) &&
                   ((elapsed[TimeW-1:WinW] != '0) ||
                    (elapsed[WinW-1:0] > cfg.window_length_us));

  assign hits_base = restart ? '0 : hits_r;

  always_comb begin
    if (hits_base == HITS_MAX) begin
      hits_nxt = HITS_MAX;
    end else begin
      hits_nxt = hits_base + HitsW'(1);
    end
  end

  assign set_deadline = hits_nxt >= cfg.burst_threshold;

  assign sum           = {1'b0, req.now} + {{(TimeW + 1 - HoldW){1'b0}}, cfg.hold_time_us};
  assign deadline_cand = sum[TimeW] ? TIME_MAX : sum[TimeW-1:0];

  always_comb begin
    window_start_nxt = window_start_r;
    deadline_nxt     = deadline_r;
    if (hit_now && restart) begin
      window_start_nxt = req.now;
    end
    if (hit_now && set_deadline) begin
      deadline_nxt = deadline_cand;
    end
  end

  // now < min(now + hold, max) reduces to a nonzero hold and now below max
  always_comb begin
    if (hit_now && set_deadline) begin
      attack_active = (cfg.hold_time_us != '0) && (req.now != TIME_MAX);
    end else begin
      attack_active = req.now < deadline_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_start_r <= '0;
      hits_r         <= '0;
      deadline_r     <= '0;
    end else begin
      window_start_r <= window_start_nxt;
      deadline_r     <= deadline_nxt;
      if (hit_now) begin
        hits_r <= hits_nxt;
      end
    end
  end
endmodule

>>> design/deauth_burst_detector.sv
// deauth burst detector: one result word per input word
// an accepted input word passes the input register and then the result register before its result shows on out_ch
// throughput: one word per cycle while out_ch is ready; input register then update logic into result register
// the result register is refilled while its word is taken, so no bubble under flow
// reset (rst_n low, synchronous) clears all counters, window and deadline state and
// loads registers with their default values
`timescale 1ns / 1ps

`include "deauth_burst_detector_assert.svh"

module deauth_burst_detector (
  input  logic                          clk,
  input  logic                          rst_n,
  dbd_stream_if.sink                    in_ch,
  dbd_stream_if.source                  out_ch,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [dbd_pkg::CfgW-1:0]      cfg_wdata
);
  import dbd_pkg::*;

  // configuration registers
  logic [WinW-1:0]  window_len_r;
  logic [HitsW-1:0] threshold_r;
  logic [HoldW-1:0] hold_r;
  logic [LenW-1:0]  min_len_r;

  logic      s1_valid;
  in_item_t  s1_item;
  logic      advance;

  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r;

  logic [CountW-1:0] frame_ctr_r, frame_ctr_nxt;
  logic [CountW-1:0] deauth_ctr_r, deauth_ctr_nxt;
  logic [AddrW-1:0]  attacker_r, attacker_nxt;
  logic              attacker_seen_r, attacker_seen_nxt;

  logic       valid_frame;
  logic [3:0] subtype;
  logic       is_hit;
  logic       attack_now;

  burst_cfg_t burst_cfg;
  burst_req_t burst_req;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_len_r <= WINDOW_RESET;
      threshold_r  <= THRESHOLD_RESET;
      hold_r       <= HOLD_RESET;
      min_len_r    <= MIN_LEN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_WINDOW:    window_len_r <= cfg_wdata[WinW-1:0];
        CFG_THRESHOLD: threshold_r  <= cfg_wdata[HitsW-1:0];
        CFG_HOLD:      hold_r       <= cfg_wdata[HoldW-1:0];
        CFG_MIN_LEN:   min_len_r    <= cfg_wdata[LenW-1:0];
        default:       ;
      endcase
    end
  end

  assign advance = s1_valid && (!out_valid_r || out_ch.ready);

  dbd_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .advance    (advance),
    .item_valid (s1_valid),
    .item       (s1_item)
  );

  assign subtype     = s1_item.frame_control_low[7:4];
  assign valid_frame = (s1_item.kind == KIND_FRAME) && s1_item.is_management &&
                       (s1_item.frame_length >= {4'b0, min_len_r});
  assign is_hit      = valid_frame &&
                       ((subtype == SUBTYPE_DEAUTH) || (subtype == SUBTYPE_DISASSOC));

  assign burst_cfg = '{window_length_us: window_len_r,
                       burst_threshold:  threshold_r,
                       hold_time_us:     hold_r};
  assign burst_req = '{fire: advance, hit: is_hit, now: s1_item.now_us};

  dbd_burst u_burst (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (burst_cfg),
    .req           (burst_req),
    .attack_active (attack_now)
  );

  always_comb begin
    frame_ctr_nxt     = frame_ctr_r;
    deauth_ctr_nxt    = deauth_ctr_r;
    attacker_nxt      = attacker_r;
    attacker_seen_nxt = attacker_seen_r;
    if (advance && valid_frame) begin
      frame_ctr_nxt = frame_ctr_r + CountW'(1);
    end
    if (advance && is_hit) begin
      deauth_ctr_nxt    = deauth_ctr_r + CountW'(1);
      attacker_nxt      = s1_item.source_address;
      attacker_seen_nxt = 1'b1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_ctr_r     <= '0;
      deauth_ctr_r    <= '0;
      attacker_r      <= '0;
      attacker_seen_r <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      frame_ctr_r     <= frame_ctr_nxt;
      deauth_ctr_r    <= deauth_ctr_nxt;
      attacker_r      <= attacker_nxt;
      attacker_seen_r <= attacker_seen_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  // result word shows the state after this word's update
  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= '{attack_active:  attack_now,
                      deauth_total:   deauth_ctr_nxt,
                      frame_total:    frame_ctr_nxt,
                      last_attacker:  attacker_nxt,
                      attacker_known: attacker_seen_nxt};
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  `DBD_ASSERT_NEXT(a_seen_sticky, clk, rst_n, attacker_seen_r, attacker_seen_r)
  `DBD_ASSERT_NEXT(a_frames_hold, clk, rst_n, !advance, $stable(frame_ctr_r))
  `DBD_ASSERT_IMPL(a_deauth_is_frame, clk, rst_n, deauth_ctr_r != $past(deauth_ctr_r), frame_ctr_r != $past(frame_ctr_r))
  `DBD_ASSERT_IMPL(a_stall_only_full, clk, rst_n, !in_ch.ready, s1_valid && out_valid_r && !out_ch.ready)
endmodule

>>> sim/deauth_burst_detector_tb.sv
// testbench for deauth_burst_detector: random and directed header words, checked
// against an in-bench status predictor; depends on dbd_pkg and dbd_stream_if
`timescale 1ns / 1ps

module deauth_burst_detector_tb;
  import dbd_pkg::*;

  localparam int IdleLimit = 500;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [1:0]        cfg_index;
  logic [CfgW-1:0]   cfg_wdata;

  dbd_stream_if #(.data_t(in_item_t))  in_if ();
  dbd_stream_if #(.data_t(out_item_t)) out_if ();

  deauth_burst_detector i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // predictor copy of the registers
  logic [WinW-1:0]   win_len;
  logic [HitsW-1:0]  hit_limit;
  logic [HoldW-1:0]  hold_len;
  logic [LenW-1:0]   min_len;

  // predictor copy of the detector state
  logic [CountW-1:0] seen_deauths;
  logic [CountW-1:0] seen_frames;
  logic [TimeW-1:0]  win_start;
  logic [HitsW-1:0]  win_hits;
  logic [TimeW-1:0]  hold_until;
  logic [AddrW-1:0]  last_src;
  logic              src_known;

  in_item_t          header_q[$];
  out_item_t         status_q[$];
  logic [TimeW-1:0]  clock_us;

  logic              in_taken;
  logic              out_taken;
  logic              calm;
  int                in_gap;
  int                out_gap;
  int                idle_cycles;
  int                err_count;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic out_item_t predict_status(input in_item_t it);
    out_item_t  r;
    logic [3:0] subtype;
    logic [48:0] sum;
    subtype = it.frame_control_low[7:4];
    if (it.kind == KIND_FRAME && it.is_management && it.frame_length >= min_len) begin
      seen_frames++;
      if (subtype == SUBTYPE_DEAUTH || subtype == SUBTYPE_DISASSOC) begin
        seen_deauths++;
        last_src  = it.source_address;
        src_known = 1'b1;
        // a clock going backwards never restarts the window
        if (it.now_us >= win_start && (it.now_us - win_start) > 48'(win_len)) begin
          win_start = it.now_us;
          win_hits  = '0;
        end
        if (win_hits != HITS_MAX) win_hits++;
        if (win_hits >= hit_limit) begin
          sum = {1'b0, it.now_us} + 49'(hold_len);
          hold_until = sum[48] ? TIME_MAX : sum[47:0];
        end
      end
    end
    r.attack_active  = (it.now_us < hold_until);
    r.deauth_total   = seen_deauths;
    r.frame_total    = seen_frames;
    r.last_attacker  = last_src;
    r.attacker_known = src_known;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("error: %s", msg);
    err_count++;
  endtask

  // compare result words, predict accepted header words, watch for a hang
  always @(posedge clk) begin : monitor
    out_item_t got;
    out_item_t want;
    in_taken  = rst_n && in_if.valid && in_if.ready;
    out_taken = rst_n && out_if.valid && out_if.ready;
    if (out_taken) begin
      got = out_if.data;
      if (status_q.size() == 0) begin
        report_mismatch("result word with nothing expected");
      end else begin
        want = status_q.pop_front();
        if (got.attack_active !== want.attack_active)
          report_mismatch($sformatf("attack_active got %0b want %0b",
                                    got.attack_active, want.attack_active));
        if (got.deauth_total !== want.deauth_total)
          report_mismatch($sformatf("deauth_total got %0h want %0h",
                                    got.deauth_total, want.deauth_total));
        if (got.frame_total !== want.frame_total)
          report_mismatch($sformatf("frame_total got %0h want %0h",
                                    got.frame_total, want.frame_total));
        if (got.last_attacker !== want.last_attacker)
          report_mismatch($sformatf("last_attacker got %0h want %0h",
                                    got.last_attacker, want.last_attacker));
        if (got.attacker_known !== want.attacker_known)
          report_mismatch($sformatf("attacker_known got %0b want %0b",
                                    got.attacker_known, want.attacker_known));
      end
    end
    if (in_taken) begin
      status_q.push_back(predict_status(in_if.data));
      // occasionally switch between randomly stalled and stall-free stretches
      if ($urandom_range(0, 99) == 0) calm = !calm;
    end
    if (in_taken || out_taken) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles == IdleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // header word driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_taken) begin
      if (in_taken) in_gap = calm ? 0 : $urandom_range(0, 3);
      if (in_gap != 0 || header_q.size() == 0) begin
        if (in_gap != 0) in_gap--;
        in_if.valid <= 1'b0;
      end else begin
        in_if.data  <= header_q.pop_front();
        in_if.valid <= 1'b1;
      end
    end
  end

  // result word sink with random stalls
  always @(negedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_taken) out_gap = calm ? 0 : $urandom_range(0, 3);
      if (out_gap != 0) begin
        out_gap--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  task automatic push_item(input kind_t k, input logic mgmt, input logic [11:0] len,
                           input logic [7:0] fc, input logic [AddrW-1:0] src,
                           input logic [TimeW-1:0] now);
    in_item_t it;
    it.kind              = k;
    it.is_management     = mgmt;
    it.frame_length      = len;
    it.frame_control_low = fc;
    it.source_address    = src;
    it.now_us            = now;
    header_q.push_back(it);
  endtask

  // mostly management frames with deauth or disassoc bursts, some noise
  function automatic in_item_t next_random_item();
    in_item_t    it;
    logic [47:0] step;
    logic [47:0] back;
    step = '0;
    case ($urandom_range(0, 9))
      0: step = '0;
      1, 2, 3, 4, 5: step = 48'($urandom_range(0, 3000));
      6, 7: step = 48'($urandom_range(0, win_len + 2));
      8: step = {16'd0, $urandom};
      default: begin
        back = 48'($urandom_range(0, 5000));
        clock_us = (clock_us > back) ? clock_us - back : '0;
      end
    endcase
    clock_us = (clock_us > TIME_MAX - step) ? TIME_MAX : clock_us + step;
    it.kind          = ($urandom_range(0, 9) == 0) ? KIND_QUERY : KIND_FRAME;
    it.is_management = ($urandom_range(0, 9) != 0);
    if ($urandom_range(0, 2) == 0)
      it.frame_length = {4'd0, min_len} + 12'($urandom_range(0, 2)) - 12'd1;
    else
      it.frame_length = 12'($urandom_range(0, 4095));
    if ($urandom_range(0, 9) < 6)
      it.frame_control_low = {($urandom_range(0, 1) != 0) ? SUBTYPE_DEAUTH : SUBTYPE_DISASSOC,
                              4'($urandom)};
    else
      it.frame_control_low = 8'($urandom);
    it.source_address = 48'({$urandom, $urandom});
    it.now_us         = clock_us;
    return it;
  endfunction

  // wait until no word is pending, in flight or expected
  task automatic drain();
    do begin
      @(posedge clk);
      #2;
    end while (header_q.size() != 0 || in_if.valid || status_q.size() != 0);
  endtask

  task automatic set_reg(input cfg_idx_t idx, input logic [CfgW-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_WINDOW:    win_len   = val[WinW-1:0];
      CFG_THRESHOLD: hit_limit = val[HitsW-1:0];
      CFG_HOLD:      hold_len  = val[HoldW-1:0];
      CFG_MIN_LEN:   min_len   = val[LenW-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [WinW-1:0] win, input logic [HitsW-1:0] thr,
                           input logic [HoldW-1:0] hold, input logic [LenW-1:0] mlen);
    drain();
    repeat (2) @(posedge clk);
    set_reg(CFG_WINDOW, CfgW'(win));
    set_reg(CFG_THRESHOLD, CfgW'(thr));
    set_reg(CFG_HOLD, CfgW'(hold));
    set_reg(CFG_MIN_LEN, CfgW'(mlen));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(input int n);
    repeat (n) header_q.push_back(next_random_item());
    drain();
  endtask

  initial begin
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = CFG_WINDOW;
    cfg_wdata    = '0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    out_if.ready = 1'b0;
    in_taken     = 1'b0;
    out_taken    = 1'b0;
    calm         = 1'b0;
    in_gap       = 0;
    out_gap      = 0;
    idle_cycles  = 0;
    err_count    = 0;
    win_len      = WINDOW_RESET;
    hit_limit    = THRESHOLD_RESET;
    hold_len     = HOLD_RESET;
    min_len      = MIN_LEN_RESET;
    seen_deauths = '0;
    seen_frames  = '0;
    win_start    = '0;
    win_hits     = '0;
    hold_until   = '0;
    last_src     = '0;
    src_known    = 1'b0;
    clock_us     = '0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed words at the register defaults
    push_item(KIND_QUERY, 1'b0, 12'd0, 8'h00, 48'd0, 48'd0);
    push_item(KIND_FRAME, 1'b0, 12'd4095, 8'hC0, 48'd1, 48'd10);
    push_item(KIND_FRAME, 1'b1, 12'd23, 8'hC0, 48'd2, 48'd20);
    push_item(KIND_FRAME, 1'b1, 12'd24, 8'h00, 48'd3, 48'd30);
    push_item(KIND_FRAME, 1'b1, 12'd4095, 8'hFF, 48'd4, 48'd40);
    // query carrying a deauth header must not count
    push_item(KIND_QUERY, 1'b1, 12'd100, 8'hC0, 48'hFFFF_FFFF_FFFF, 48'd50);
    push_item(KIND_FRAME, 1'b1, 12'd30, 8'hC0, 48'd0, 48'd100);
    push_item(KIND_FRAME, 1'b1, 12'd30, 8'hA8, 48'hFFFF_FFFF_FFFF, 48'd200);
    push_item(KIND_FRAME, 1'b1, 12'd30, 8'hCF, 48'h0123_4567_89AB, 48'd300);
    push_item(KIND_FRAME, 1'b1, 12'd30, 8'hB0, 48'd5, 48'd400);
    push_item(KIND_FRAME, 1'b1, 12'd30, 8'hA0, 48'hA5A5_5A5A_A5A5, 48'd500);
    push_item(KIND_FRAME, 1'b1, 12'd30, 8'hC0, 48'h5A5A_A5A5_5A5A, 48'd600);
    // flag held up to one microsecond before the deadline
    push_item(KIND_QUERY, 1'b0, 12'd0, 8'h00, 48'd0, 48'd5000599);
    push_item(KIND_QUERY, 1'b0, 12'd0, 8'h00, 48'd0, 48'd5000600);
    // window restart, exact window boundary, then one past it
    push_item(KIND_FRAME, 1'b1, 12'd30, 8'hC0, 48'd6, 48'd5000600);
    push_item(KIND_FRAME, 1'b1, 12'd30, 8'hC0, 48'd7, 48'd6000600);
    push_item(KIND_FRAME, 1'b1, 12'd30, 8'hC0, 48'd8, 48'd6000601);
    // clock going backwards keeps the window
    push_item(KIND_FRAME, 1'b1, 12'd30, 8'hC0, 48'd9, 48'd100);
    push_item(KIND_FRAME, 1'b1, 12'd30, 8'hA0, 48'd10, 48'd200);
    push_item(KIND_FRAME, 1'b1, 12'd30, 8'hC0, 48'd11, 48'd300);
    push_item(KIND_FRAME, 1'b1, 12'd30, 8'hA0, 48'd12, 48'd400);
    push_item(KIND_QUERY, 1'b0, 12'd0, 8'h00, 48'd0, TIME_MAX);
    drain();

    clock_us = 48'd10000;
    run_random(300);
    configure(24'd1, 16'd1, 28'd0, 8'd0);
    run_random(250);
    configure(24'hFF_FFFF, 16'hFFFF, 28'hFFF_FFFF, 8'hFF);
    run_random(200);
    // zero threshold and zero window
    configure(24'd0, 16'd0, 28'd1, 8'd24);
    run_random(250);
    repeat (3) begin
      configure(24'($urandom_range(0, 2000000)), 16'($urandom_range(0, 8)),
                28'($urandom_range(0, 20000)), 8'($urandom_range(0, 255)));
      run_random(200);
    end

    // times near the top: deadline saturates
    configure(24'd5000, 16'd2, 28'hFFF_FFFF, 8'd24);
    clock_us = TIME_MAX - 48'($urandom_range(0, 2000000));
    run_random(150);
    push_item(KIND_FRAME, 1'b1, 12'd24, 8'hC0, 48'hFFFF_FFFF_FFFF, TIME_MAX);
    push_item(KIND_FRAME, 1'b1, 12'd24, 8'hA0, 48'h8000_0000_0001, TIME_MAX);
    drain();

    repeat (3) @(posedge clk);
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> deauth_burst_detector.f
+incdir+design
design/dbd_pkg.sv
design/dbd_stream_if.sv
design/dbd_in_reg.sv
design/dbd_burst.sv
design/deauth_burst_detector.sv
sim/deauth_burst_detector_tb.sv
